/* rtl/sha256_stream_hasher_unit_assert.svh */
// Assertion macros used by the checker of the hasher.
`ifndef SHA256_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA256_STREAM_HASHER_UNIT_ASSERT_SVH

// Condition c must hold in the same cycle as a.
`define SHA_ASSERT_SAME(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("sha256 check failed");

// Condition c must hold in the cycle after a.
`define SHA_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("sha256 check failed");

`endif

/* rtl/sha256sh_pkg.sv */
package sha256sh_pkg;

  localparam int unsigned BUF_WORDS  = 16;
  localparam int unsigned HASH_WORDS = 8;
  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [5:0]  LEN_POS    = 6'd56;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  function automatic logic [31:0] init_h(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] v;
    case (idx)
      6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
      6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
      6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
      6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
      6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
      6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
      6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
      6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
      6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
      6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
      6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
      6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
      6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
      6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
      6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
      6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
      6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
      6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
      6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
      6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
      6'd62: v = 32'hbef9a3f7;
      default: v = 32'hc67178f2;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

/* rtl/sha256sh_ram.sv */
module sha256sh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sha256_stream_hasher_unit.sv */
// Streaming SHA-256 hasher. Each input word carries one message byte (kind 0)
// or a finish request (kind 1). Bytes are packed four at a time into 32-bit
// words and kept in a 16-word block memory; the eight chaining words live in a
// second 8-word memory whose entries read as the standard initial values until
// first written after a reset or a finished message. The byte that completes
// a 64-byte block is followed by a compression that loads the chaining words
// and the message words into the round registers through the single read
// port of each memory, runs 64 rounds at one round per cycle, then adds the
// result back into the chaining memory.
// A finish writes the padding words from the 0x80 marker word to the end of
// the block, plus a second padding block when 56 or more bytes were held,
// runs one or two compressions, then delivers the digest as eight output
// words, index 0 first, last_word set on index 7, each one offered once the
// previous is taken. in_ready is high only while the block is idle, and after
// the eighth word is taken the block starts a new message with a zero length.
module sha256_stream_hasher_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sha256sh_pkg::in_word_t  in_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sha256sh_pkg::out_word_t out_word
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,  // taking input words
    ST_PADW  = 8'b0000_0010,  // writing padding words
    ST_LOAD  = 8'b0000_0100,  // loading chaining and message words
    ST_ROUND = 8'b0000_1000,  // 64 compression rounds
    ST_WB    = 8'b0001_0000,  // chaining update write-back
    ST_OUTRD = 8'b0010_0000,  // read one digest word
    ST_OUTLD = 8'b0100_0000,  // capture it into the output register
    ST_OUTW  = 8'b1000_0000   // wait for the consumer
  } state_t;

  state_t state_r, state_nxt;

  // Shared step counter: load step, round number, write-back step,
  // padding word index, digest word index.
  logic [5:0]  ctr_r, ctr_nxt;
  logic [5:0]  fill_r, fill_nxt;         // bytes held in the current block
  logic [63:0] bits_r, bits_nxt;         // message length in bits
  logic        pad_r, pad_nxt;           // compression belongs to a finish
  logic        two_r, two_nxt;           // padding needs two blocks
  logic        second_r, second_nxt;     // working on the second pad block
  logic [7:0]  fresh_r, fresh_nxt;       // chaining entry still at initial value

  // Datapath registers.
  logic [23:0] pack_r, pack_nxt;         // up to three bytes of a partial word
  logic [63:0] len_r, len_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [2:0]  hrd_idx_r;
  logic [31:0] r_r [8];
  logic [31:0] r_nxt [8];
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  sha256sh_pkg::out_word_t out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  // Memory ports.
  logic        buf_we;
  logic [3:0]  buf_waddr, buf_raddr;
  logic [31:0] buf_wdata, buf_rdata;
  logic        h_we;
  logic [2:0]  h_waddr, h_raddr;
  logic [31:0] h_wdata, h_rdata;

  logic [31:0] hval;
  logic [31:0] sched_w;
  logic [31:0] t1, t2;
  logic [31:0] pad_word;
  logic [31:0] mark_word;
  logic [2:0]  wb_idx;
  logic        in_fire;

  sha256sh_ram #(
    .WIDTH(32),
    .DEPTH(sha256sh_pkg::BUF_WORDS)
  ) u_buf_ram (
    .clk  (clk),
    .we   (buf_we),
    .waddr(buf_waddr),
    .wdata(buf_wdata),
    .raddr(buf_raddr),
    .rdata(buf_rdata)
  );

  sha256sh_ram #(
    .WIDTH(32),
    .DEPTH(sha256sh_pkg::HASH_WORDS)
  ) u_hash_ram (
    .clk  (clk),
    .we   (h_we),
    .waddr(h_waddr),
    .wdata(h_wdata),
    .raddr(h_raddr),
    .rdata(h_rdata)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // Chaining entry never written since restart reads as the initial value.
  assign hval = fresh_r[hrd_idx_r] ? sha256sh_pkg::init_h(hrd_idx_r) : h_rdata;

  // Message schedule: window holds W[t]..W[t+15]; produce W[t+16].
  assign sched_w = w_r[0] + sha256sh_pkg::small_sigma0(w_r[1]) + w_r[9]
                 + sha256sh_pkg::small_sigma1(w_r[14]);

  // Round function.
  assign t1 = r_r[7] + sha256sh_pkg::big_sigma1(r_r[4])
            + ((r_r[4] & r_r[5]) ^ (~r_r[4] & r_r[6]))
            + sha256sh_pkg::round_k(ctr_r) + w_r[0];
  assign t2 = sha256sh_pkg::big_sigma0(r_r[0])
            + ((r_r[0] & r_r[1]) ^ (r_r[0] & r_r[2]) ^ (r_r[1] & r_r[2]));

  // Word holding the 0x80 marker: held bytes, marker, then zeros.
  always_comb begin
    case (pos_r[1:0])
      2'd0:    mark_word = {sha256sh_pkg::PAD_BYTE, 24'h0};
      2'd1:    mark_word = {pack_r[7:0], sha256sh_pkg::PAD_BYTE, 16'h0};
      2'd2:    mark_word = {pack_r[15:0], sha256sh_pkg::PAD_BYTE, 8'h0};
      default: mark_word = {pack_r[23:0], sha256sh_pkg::PAD_BYTE};
    endcase
  end

  always_comb begin
    if (!second_r && ctr_r[3:0] == pos_r[5:2]) begin
      pad_word = mark_word;
    end else if ((!two_r || second_r) && ctr_r[3:0] == 4'd14) begin
      pad_word = len_r[63:32];
    end else if ((!two_r || second_r) && ctr_r[3:0] == 4'd15) begin
      pad_word = len_r[31:0];
    end else begin
      pad_word = 32'h0;
    end
  end

  assign wb_idx = 3'(ctr_r - 6'd1);

  always_comb begin
    state_nxt     = state_r;
    ctr_nxt       = ctr_r;
    fill_nxt      = fill_r;
    bits_nxt      = bits_r;
    pad_nxt       = pad_r;
    two_nxt       = two_r;
    second_nxt    = second_r;
    fresh_nxt     = fresh_r;
    pack_nxt      = pack_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    r_nxt         = r_r;
    w_nxt         = w_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    buf_we        = 1'b0;
    buf_waddr     = ctr_r[3:0];
    buf_wdata     = pad_word;
    buf_raddr     = ctr_r[3:0];
    h_we          = 1'b0;
    h_waddr       = wb_idx;
    h_wdata       = hval + r_r[0];
    h_raddr       = ctr_r[2:0];

    case (state_r)
      ST_IDLE: begin
        if (in_fire && !in_word.kind) begin
          pack_nxt = {pack_r[15:0], in_word.data_byte};
          bits_nxt = bits_r + 64'd8;
          fill_nxt = fill_r + 6'd1;
          if (fill_r[1:0] == 2'd3) begin
            buf_we    = 1'b1;
            buf_waddr = fill_r[5:2];
            buf_wdata = {pack_r, in_word.data_byte};
          end
          if (fill_r == 6'd63) begin
            pad_nxt   = 1'b0;
            ctr_nxt   = 6'd0;
            state_nxt = ST_LOAD;
          end
        end else if (in_fire) begin
          len_nxt    = bits_r;
          pos_nxt    = fill_r;
          pad_nxt    = 1'b1;
          two_nxt    = (fill_r >= sha256sh_pkg::LEN_POS);
          second_nxt = 1'b0;
          ctr_nxt    = {2'b00, fill_r[5:2]};
          state_nxt  = ST_PADW;
        end
      end

      ST_PADW: begin
        buf_we = 1'b1;
        if (ctr_r[3:0] == 4'd15) begin
          ctr_nxt   = 6'd0;
          state_nxt = ST_LOAD;
        end else begin
          ctr_nxt = ctr_r + 6'd1;
        end
      end

      ST_LOAD: begin
        // Step k reads message word k and chaining word k; data lands at k+1.
        if (ctr_r != 6'd0) begin
          for (int i = 0; i < 15; i++) begin
            w_nxt[i] = w_r[i+1];
          end
          w_nxt[15] = buf_rdata;
          if (ctr_r <= 6'd8) begin
            for (int i = 0; i < 7; i++) begin
              r_nxt[i] = r_r[i+1];
            end
            r_nxt[7] = hval;
          end
        end
        if (ctr_r == 6'd16) begin
          ctr_nxt   = 6'd0;
          state_nxt = ST_ROUND;
        end else begin
          ctr_nxt = ctr_r + 6'd1;
        end
      end

      ST_ROUND: begin
        r_nxt[7] = r_r[6];
        r_nxt[6] = r_r[5];
        r_nxt[5] = r_r[4];
        r_nxt[4] = r_r[3] + t1;
        r_nxt[3] = r_r[2];
        r_nxt[2] = r_r[1];
        r_nxt[1] = r_r[0];
        r_nxt[0] = t1 + t2;
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[15] = sched_w;
        if (ctr_r == 6'd63) begin
          ctr_nxt   = 6'd0;
          state_nxt = ST_WB;
        end else begin
          ctr_nxt = ctr_r + 6'd1;
        end
      end

      ST_WB: begin
        // Read entry k while entry k-1 is written: never the same address.
        if (ctr_r != 6'd0) begin
          h_we              = 1'b1;
          fresh_nxt[wb_idx] = 1'b0;
          for (int i = 0; i < 7; i++) begin
            r_nxt[i] = r_r[i+1];
          end
          r_nxt[7] = r_r[0];
        end
        if (ctr_r == 6'd8) begin
          ctr_nxt = 6'd0;
          if (pad_r && two_r && !second_r) begin
            second_nxt = 1'b1;
            state_nxt  = ST_PADW;
          end else if (pad_r) begin
            state_nxt = ST_OUTRD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          ctr_nxt = ctr_r + 6'd1;
        end
      end

      ST_OUTRD: begin
        state_nxt = ST_OUTLD;
      end

      ST_OUTLD: begin
        out_nxt.digest_word = hval;
        out_nxt.word_index  = ctr_r[2:0];
        out_nxt.last_word   = (ctr_r[2:0] == 3'd7);
        out_valid_nxt       = 1'b1;
        state_nxt           = ST_OUTW;
      end

      ST_OUTW: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (ctr_r[2:0] == 3'd7) begin
            // Start the next message from the initial chaining values.
            fresh_nxt = '1;
            fill_nxt  = 6'd0;
            bits_nxt  = 64'd0;
            pad_nxt   = 1'b0;
            ctr_nxt   = 6'd0;
            state_nxt = ST_IDLE;
          end else begin
            ctr_nxt   = ctr_r + 6'd1;
            state_nxt = ST_OUTRD;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ctr_r       <= 6'd0;
      fill_r      <= 6'd0;
      bits_r      <= 64'd0;
      pad_r       <= 1'b0;
      two_r       <= 1'b0;
      second_r    <= 1'b0;
      fresh_r     <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctr_r       <= ctr_nxt;
      fill_r      <= fill_nxt;
      bits_r      <= bits_nxt;
      pad_r       <= pad_nxt;
      two_r       <= two_nxt;
      second_r    <= second_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pack_r    <= pack_nxt;
    len_r     <= len_nxt;
    pos_r     <= pos_nxt;
    hrd_idx_r <= h_raddr;
    r_r       <= r_nxt;
    w_r       <= w_nxt;
    out_r     <= out_nxt;
  end

endmodule

/* rtl/sha256sh_checker.sv */
`include "sha256_stream_hasher_unit_assert.svh"

module sha256sh_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input sha256sh_pkg::in_word_t  in_word,
  input logic                    out_valid,
  input logic                    out_ready,
  input sha256sh_pkg::out_word_t out_word
);

  // A stalled digest word stays put.
  `SHA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word))

  // No input is taken while the digest is being delivered.
  `SHA_ASSERT_SAME(a_busy_out, clk, rst_n, out_valid, !in_ready)

  // Only index 7 carries the last flag.
  `SHA_ASSERT_SAME(a_last_idx, clk, rst_n, out_valid && out_word.last_word, out_word.word_index == 3'd7)

  // More digest words follow a non-final one, so input stays closed.
  `SHA_ASSERT_NEXT(a_more_words, clk, rst_n, out_valid && out_ready && !out_word.last_word, !in_ready)

  // A finish starts padding; nothing new is taken on the next edge.
  `SHA_ASSERT_NEXT(a_finish_busy, clk, rst_n, in_valid && in_ready && in_word.kind, !in_ready)

endmodule

bind sha256_stream_hasher_unit sha256sh_checker u_sha256sh_checker (.*);

/* tb/sha256sh_tb_pkg.sv */
package sha256sh_tb_pkg;

  import sha256sh_pkg::*;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam logic [7:0]  PAD_MARK      = 8'h80;
  localparam int unsigned LENGTH_OFFSET = 56;

  // Tracks message state per accepted input word and holds the digest words
  // that the block still owes.
  class digest_scoreboard;
    logic [31:0] round_const[64];
    logic [31:0] start_h[8];
    logic [31:0] chain_h[8];
    logic [7:0]  msg_block[64];
    logic [5:0]  fill;
    logic [63:0] msg_bits;
    out_word_t   expected_words[$];
    int unsigned failures;

    function new();
      round_const = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      start_h = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      foreach (msg_block[i]) msg_block[i] = '0;
      failures = 0;
      restart();
    endfunction

    function void restart();
      chain_h  = start_h;
      fill     = '0;
      msg_bits = '0;
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    // One 64-round pass over msg_block, folded into chain_h.
    function void compress_block();
      logic [31:0] w[64];
      logic [31:0] a, b, c, d, e, f, g, h;
      logic [31:0] s0, s1, ch, mj, t1, t2;
      for (int i = 0; i < 16; i++) begin
        w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      end
      for (int i = 16; i < 64; i++) begin
        s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
      e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
      for (int i = 0; i < 64; i++) begin
        s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
        ch = (e & f) ^ (~e & g);
        t1 = h + s1 + ch + round_const[i] + w[i];
        s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
        mj = (a & b) ^ (a & c) ^ (b & c);
        t2 = s0 + mj;
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
      chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endfunction

    function void absorb_word(in_word_t iw);
      logic [63:0] len;
      int          pos;
      out_word_t   ow;
      if (iw.kind == KIND_BYTE) begin
        msg_block[fill] = iw.data_byte;
        msg_bits += 64'd8;
        fill = fill + 6'd1;
        if (fill == 6'd0) compress_block();
        return;
      end
      // finish: pad marker, zeros, big-endian bit length; spills when >= 56 held
      len = msg_bits;
      pos = int'(fill);
      msg_block[pos] = PAD_MARK;
      pos++;
      if (pos > LENGTH_OFFSET) begin
        for (int i = pos; i < 64; i++) msg_block[i] = '0;
        compress_block();
        pos = 0;
      end
      for (int i = pos; i < LENGTH_OFFSET; i++) msg_block[i] = '0;
      for (int i = 0; i < 8; i++) msg_block[LENGTH_OFFSET + i] = len[63 - 8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        ow.digest_word = chain_h[i];
        ow.word_index  = 3'(i);
        ow.last_word   = (i == 7);
        expected_words.push_back(ow);
      end
      restart();
    endfunction

    function void check_digest_word(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        $error("unexpected digest word %h, index %0d", got.digest_word, got.word_index);
        failures++;
        return;
      end
      want = expected_words.pop_front();
      if (got.digest_word !== want.digest_word) begin
        $error("digest_word: expected %h, actual %h", want.digest_word, got.digest_word);
        failures++;
      end
      if (got.word_index !== want.word_index) begin
        $error("word_index: expected %0d, actual %0d", want.word_index, got.word_index);
        failures++;
      end
      if (got.last_word !== want.last_word) begin
        $error("last_word: expected %0b, actual %0b", want.last_word, got.last_word);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

endpackage

/* tb/sha256_stream_hasher_unit_tb.sv */
// Checks the streaming SHA-256 hasher against an in-bench digest predictor.
// Message bytes and finish words go in over a valid/ready port with random
// gaps; digest words come out under random backpressure and are compared
// field by field against the predicted digest, in order.
module sha256_stream_hasher_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import sha256sh_pkg::*;
  import sha256sh_tb_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 460;
  // longest quiet stretch of a correct run is a two-block finish plus a long
  // output stall; this leaves ample margin
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned TAIL_CYCLES  = 40;
  // message lengths that land the finish on the one/two-block padding edge
  localparam int unsigned EDGE_LENGTHS[8] = '{55, 56, 57, 63, 64, 65, 119, 120};

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;

  digest_scoreboard sb = new();
  in_word_t         word_stream[$];
  int unsigned      stall_cycles = 0;

  sha256_stream_hasher_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly no gap or a short one, now and then a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random message body of n_bytes, then a finish word with a junk byte
  // (the byte of a finish must be ignored).
  function automatic void add_message(int unsigned n_bytes);
    for (int i = 0; i < n_bytes; i++) begin
      word_stream.push_back(in_word_t'{kind: KIND_BYTE, data_byte: 8'($urandom_range(255))});
    end
    word_stream.push_back(in_word_t'{kind: KIND_FINISH, data_byte: 8'($urandom_range(255))});
  endfunction

  // Sender: valid stays up until the word is taken; a gap only drops it at
  // the edge that took the previous word. Quiet stretches run gap-free.
  task automatic feed_words();
    int unsigned gap;
    int unsigned quiet;
    quiet = 0;
    foreach (word_stream[i]) begin
      if (quiet > 0) begin
        gap = 0;
        quiet--;
      end else begin
        gap = pick_gap();
        if ($urandom_range(9) == 0) quiet = $urandom_range(16, 96);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_word  <= word_stream[i];
      in_valid <= 1'b1;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;
  endtask

  // Receiver: ready runs of random length broken by random stalls, with an
  // occasional long run so whole digests also drain back to back.
  initial begin
    int unsigned run;
    int unsigned stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      run = ($urandom_range(9) == 0) ? $urandom_range(80, 240) : $urandom_range(1, 20);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Handshake monitor: samples pre-edge values; input before output so a
  // finish's digest is queued before any of its words could be checked.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else begin
      if (in_valid && in_ready) sb.absorb_word(in_word);
      if (out_valid && out_ready) sb.check_digest_word(out_word);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Watchdog: too long with no word moving on either side.
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int unsigned random_items;
    int unsigned n_bytes;
    int unsigned pick;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_word  <= '0;

    // Directed: empty message, single all-zero and all-one bytes, "abc".
    word_stream.push_back(in_word_t'{kind: KIND_FINISH, data_byte: 8'hff});
    word_stream.push_back(in_word_t'{kind: KIND_BYTE, data_byte: 8'h00});
    word_stream.push_back(in_word_t'{kind: KIND_FINISH, data_byte: 8'h00});
    word_stream.push_back(in_word_t'{kind: KIND_BYTE, data_byte: 8'hff});
    word_stream.push_back(in_word_t'{kind: KIND_FINISH, data_byte: 8'h5a});
    word_stream.push_back(in_word_t'{kind: KIND_BYTE, data_byte: 8'h61});
    word_stream.push_back(in_word_t'{kind: KIND_BYTE, data_byte: 8'h62});
    word_stream.push_back(in_word_t'{kind: KIND_BYTE, data_byte: 8'h63});
    word_stream.push_back(in_word_t'{kind: KIND_FINISH, data_byte: 8'ha5});

    // Random messages: many short, many on the padding edges (one vs two
    // extra blocks, exact block multiples), some mid-size, a few multi-block.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        n_bytes = $urandom_range(0, 12);
      end else if (pick < 75) begin
        n_bytes = EDGE_LENGTHS[$urandom_range(7)];
      end else if (pick < 95) begin
        n_bytes = $urandom_range(0, 70);
      end else begin
        n_bytes = $urandom_range(128, 200);
      end
      add_message(n_bytes);
      random_items += n_bytes + 1;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    feed_words();
    // let the monitor note the last accepted word before looking at the queue
    @(posedge clk);

    // drain: every digest word owed, then a quiet tail to catch extras
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/sha256sh_pkg.sv
rtl/sha256sh_ram.sv
rtl/sha256_stream_hasher_unit.sv
rtl/sha256sh_checker.sv
tb/sha256sh_tb_pkg.sv
tb/sha256_stream_hasher_unit_tb.sv
